// ===== rtl/vector_distance_metrics_macros.svh =====
// assertion macros shared by the vector distance metrics rtl
`ifndef VECTOR_DISTANCE_METRICS_MACROS_SVH
`define VECTOR_DISTANCE_METRICS_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define VDM_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen outside reset
`define VDM_ASSERT_NEVER(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define VDM_ASSERT(name, clk, rst, prop, msg)
`define VDM_ASSERT_NEVER(name, clk, rst, cond, msg)

`endif

`endif

// ===== rtl/vdm_pkg.sv =====
// shared types, constants and helpers for the vector distance metrics block
`timescale 1ns / 1ps
`default_nettype none

package vdm_pkg;

   localparam int OUT_WIDTH          = 48;
   localparam int ELEM_WIDTH_DEFAULT = 16;
   localparam int ACC_WIDTH_DEFAULT  = 48;
   localparam int NUM_SUMS           = 4;

   // accumulator slots, also the order of multiplier passes
   localparam logic [1:0] SUM_DOT = 2'd0;
   localparam logic [1:0] SUM_NA  = 2'd1;
   localparam logic [1:0] SUM_NB  = 2'd2;
   localparam logic [1:0] SUM_DSQ = 2'd3;

   localparam logic signed [63:0] OUT_MAX = 64'sd140737488355327;
   localparam logic signed [63:0] OUT_MIN = -64'sd140737488355328;

   typedef enum logic [1:0] {
      MET_DOT  = 2'd0,
      MET_COS  = 2'd1,
      MET_EUC  = 2'd2,
      MET_NONE = 2'd3
   } metric_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_FIN,
      ST_HOLD
   } ctl_state_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_SQA,
      F_SQB,
      F_SQE,
      F_MUL,
      F_CMP,
      F_DIV,
      F_DONE
   } fin_state_type;

   typedef struct packed {
      logic                        done;
      logic signed [OUT_WIDTH-1:0] value;
      logic                        zero_norm;
   } result_type;

   function automatic logic signed [OUT_WIDTH-1:0] clamp_out(input logic signed [63:0] v);
      logic signed [63:0] t;
      t = v;
      if (t > OUT_MAX) begin
         t = OUT_MAX;
      end else if (t < OUT_MIN) begin
         t = OUT_MIN;
      end
      return t[OUT_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/vdm_mac.sv =====
// shared multiplier and saturating accumulators, four passes per element pair
`timescale 1ns / 1ps
`default_nettype none

module vdm_mac #(
   parameter int ELEM_WIDTH = 16,
   parameter int ACC_WIDTH  = 48
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        clear,
   input  logic signed [ELEM_WIDTH-1:0] elem_a,
   input  logic signed [ELEM_WIDTH-1:0] elem_b,
   output logic                        done,
   output logic signed [ACC_WIDTH-1:0] dot_sum,
   output logic signed [ACC_WIDTH-1:0] norm_a_sum,
   output logic signed [ACC_WIDTH-1:0] norm_b_sum,
   output logic signed [ACC_WIDTH-1:0] diff_sq_sum,
   output logic                        sat_flag
);
   import vdm_pkg::*;

   localparam int OPW = ELEM_WIDTH + 1;
   localparam int PW  = 2 * OPW;
   localparam int SW  = ((ACC_WIDTH > PW) ? ACC_WIDTH : PW) + 1;
   localparam logic [2:0] LAST_STEP = 3'(NUM_SUMS);
   localparam logic signed [SW-1:0] ACC_HI =
      {{(SW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
   localparam logic signed [SW-1:0] ACC_LO = ~ACC_HI;

   logic signed [ELEM_WIDTH-1:0] a_ff, b_ff;
   logic                         active_ff;
   logic                         done_ff;
   logic [2:0]                   step_ff;
   logic signed [PW-1:0]         prod_ff;
   logic signed [ACC_WIDTH-1:0]  acc_ff [NUM_SUMS];
   logic                         sat_ff;

   logic signed [OPW-1:0]        diff, op_x, op_y;
   logic [1:0]                   wr_idx;
   logic signed [SW-1:0]         sum;
   logic                         ovf_hi, ovf_lo;
   logic signed [ACC_WIDTH-1:0]  acc_new;

   assign diff = OPW'(a_ff) - OPW'(b_ff);

   always_comb begin
      case (step_ff[1:0])
         SUM_DOT: begin
            op_x = OPW'(a_ff);
            op_y = OPW'(b_ff);
         end
         SUM_NA: begin
            op_x = OPW'(a_ff);
            op_y = OPW'(a_ff);
         end
         SUM_NB: begin
            op_x = OPW'(b_ff);
            op_y = OPW'(b_ff);
         end
         default: begin
            op_x = diff;
            op_y = diff;
         end
      endcase
   end

   // the product from the previous pass lands in its accumulator
   assign wr_idx  = 2'(step_ff - 3'd1);
   assign sum     = SW'(acc_ff[wr_idx]) + SW'(prod_ff);
   assign ovf_hi  = sum > ACC_HI;
   assign ovf_lo  = sum < ACC_LO;
   assign acc_new = ovf_hi ? ACC_HI[ACC_WIDTH-1:0] :
                    ovf_lo ? ACC_LO[ACC_WIDTH-1:0] : sum[ACC_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (active_ff) begin
         prod_ff <= op_x * op_y;
      end
      if (start) begin
         a_ff <= elem_a;
         b_ff <= elem_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         step_ff   <= 3'd0;
         sat_ff    <= 1'b0;
         for (int i = 0; i < NUM_SUMS; i++) begin
            acc_ff[i] <= '0;
         end
      end else begin
         // all four sums hold the pair once done rises with the accumulate of the last product
         done_ff <= active_ff && (step_ff == LAST_STEP);
         if (clear) begin
            sat_ff <= 1'b0;
            for (int i = 0; i < NUM_SUMS; i++) begin
               acc_ff[i] <= '0;
            end
         end
         if (start) begin
            active_ff <= 1'b1;
            step_ff   <= 3'd0;
         end else if (active_ff) begin
            step_ff <= step_ff + 3'd1;
            if (step_ff != 3'd0) begin
               acc_ff[wr_idx] <= acc_new;
               sat_ff         <= sat_ff | ovf_hi | ovf_lo;
            end
            if (step_ff == LAST_STEP) begin
               active_ff <= 1'b0;
            end
         end
      end
   end

   assign done        = done_ff;
   assign dot_sum     = acc_ff[SUM_DOT];
   assign norm_a_sum  = acc_ff[SUM_NA];
   assign norm_b_sum  = acc_ff[SUM_NB];
   assign diff_sq_sum = acc_ff[SUM_DSQ];
   assign sat_flag    = sat_ff;

endmodule

`default_nettype wire

// ===== rtl/vdm_finish.sv =====
// end of vector sequencer: bitwise square roots, norm product and restoring divide
`timescale 1ns / 1ps
`default_nettype none

module vdm_finish #(
   parameter int ELEM_WIDTH = 16,
   parameter int ACC_WIDTH  = 48
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  vdm_pkg::metric_type         metric_select,
   input  logic signed [ACC_WIDTH-1:0] dot_sum,
   input  logic signed [ACC_WIDTH-1:0] norm_a_sum,
   input  logic signed [ACC_WIDTH-1:0] norm_b_sum,
   input  logic signed [ACC_WIDTH-1:0] diff_sq_sum,
   output vdm_pkg::result_type         result
);
   import vdm_pkg::*;

   localparam int FB    = ELEM_WIDTH - 1;
   localparam int SQ    = ACC_WIDTH / 2;
   localparam int DEN_W = 2 * SQ;
   localparam int CNT_W = $clog2(SQ + FB + 1);
   localparam logic [ACC_WIDTH-1:0] BIT0 = ACC_WIDTH'({1'b1, {(2*SQ-2){1'b0}}});
   localparam logic signed [OUT_WIDTH-1:0] COS_ONE = OUT_WIDTH'(1) <<< FB;
   localparam logic signed [OUT_WIDTH-1:0] COS_MAX = COS_ONE - OUT_WIDTH'(1);

   fin_state_type state_ff, state_in;

   logic [ACC_WIDTH-1:0]        n_ff, res_ff, bit_ff, mag_ff;
   logic [CNT_W-1:0]            cnt_ff;
   logic [SQ-1:0]               root_a_ff, root_b_ff;
   logic [DEN_W-1:0]            den_ff;
   logic                        neg_ff, zero_ff;
   logic [ACC_WIDTH:0]          r_ff;
   logic [FB-1:0]               q_ff;
   logic signed [OUT_WIDTH-1:0] val_ff;

   logic [ACC_WIDTH-1:0] trial, n_nx, res_nx;
   logic                 sq_ge, sq_last, div_last, norm_bad, mag_big;
   logic [ACC_WIDTH:0]   r_sh, r_nx;
   logic                 dv_ge;
   logic [FB-1:0]        q_nx;
   logic [ACC_WIDTH-1:0] euc_in;

   // one digit of the square root per cycle
   assign trial   = res_ff + bit_ff;
   assign sq_ge   = n_ff >= trial;
   assign n_nx    = sq_ge ? (n_ff - trial) : n_ff;
   assign res_nx  = sq_ge ? ((res_ff >> 1) + bit_ff) : (res_ff >> 1);
   assign sq_last = cnt_ff == CNT_W'(SQ - 1);

   // one quotient bit per cycle
   assign r_sh     = {r_ff[ACC_WIDTH-1:0], 1'b0};
   assign dv_ge    = r_sh >= (ACC_WIDTH+1)'(den_ff);
   assign r_nx     = dv_ge ? (r_sh - (ACC_WIDTH+1)'(den_ff)) : r_sh;
   assign q_nx     = {q_ff[FB-2:0], dv_ge};
   assign div_last = cnt_ff == CNT_W'(FB - 1);

   assign norm_bad = (norm_a_sum <= 0) || (norm_b_sum <= 0);
   assign mag_big  = mag_ff >= ACC_WIDTH'(den_ff);
   assign euc_in   = (diff_sq_sum > 0) ? diff_sq_sum : '0;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (start) begin
               case (metric_select)
                  MET_COS: state_in = norm_bad ? F_DONE : F_SQA;
                  MET_EUC: state_in = F_SQE;
                  default: state_in = F_DONE;
               endcase
            end
         end
         F_SQA:  if (sq_last) state_in = F_SQB;
         F_SQB:  if (sq_last) state_in = F_MUL;
         F_SQE:  if (sq_last) state_in = F_DONE;
         F_MUL:  state_in = F_CMP;
         F_CMP:  state_in = mag_big ? F_DONE : F_DIV;
         F_DIV:  if (div_last) state_in = F_DONE;
         F_DONE: state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         F_IDLE: begin
            if (start) begin
               cnt_ff  <= '0;
               res_ff  <= '0;
               bit_ff  <= BIT0;
               n_ff    <= (metric_select == MET_COS) ? norm_a_sum : euc_in;
               neg_ff  <= dot_sum < 0;
               mag_ff  <= (dot_sum < 0) ? ACC_WIDTH'(-dot_sum) : dot_sum;
               zero_ff <= (metric_select == MET_COS) && norm_bad;
               val_ff  <= (metric_select == MET_DOT) ? clamp_out(64'(dot_sum)) : '0;
            end
         end
         F_SQA, F_SQB, F_SQE: begin
            n_ff   <= n_nx;
            res_ff <= res_nx;
            bit_ff <= bit_ff >> 2;
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (sq_last) begin
               cnt_ff <= '0;
               res_ff <= '0;
               bit_ff <= BIT0;
               n_ff   <= norm_b_sum;
               if (state_ff == F_SQA) begin
                  root_a_ff <= res_nx[SQ-1:0];
               end
               if (state_ff == F_SQB) begin
                  root_b_ff <= res_nx[SQ-1:0];
               end
               if (state_ff == F_SQE) begin
                  val_ff <= OUT_WIDTH'(res_nx);
               end
            end
         end
         F_MUL: begin
            den_ff <= root_a_ff * root_b_ff;
         end
         F_CMP: begin
            r_ff   <= (ACC_WIDTH+1)'(mag_ff);
            q_ff   <= '0;
            cnt_ff <= '0;
            if (mag_big) begin
               val_ff <= neg_ff ? -COS_ONE : COS_MAX;
            end
         end
         F_DIV: begin
            r_ff   <= r_nx;
            q_ff   <= q_nx;
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (div_last) begin
               val_ff <= neg_ff ? -OUT_WIDTH'(q_nx) : OUT_WIDTH'(q_nx);
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      result.done      = state_ff == F_DONE;
      result.value     = val_ff;
      result.zero_norm = zero_ff;
   end

endmodule

`default_nettype wire

// ===== rtl/vector_distance_metrics.sv =====
// top level: stream handshake, metric select register, control and result register
//
// channel  dir  beat fields (low bit up)
// req      in   tdata: elem_a, elem_b; tlast: last_elem
// rsp      out  tdata: metric_value; tuser: zero_norm, saturated
// csr      in   wr_data: metric_select
//
// each element pair takes four passes through one shared multiplier, the accumulate of
// the last product and a done strobe, then the top returns to ready for the next pair.
// after the last pair is accepted, dot product goes straight to the result, euclidean
// adds a square root, and cosine two square roots, a norm product and a divide (none
// if a norm is not positive); square root and divide give one digit per cycle.
// a waiting result sits in the output register; new pairs are taken meanwhile,
// and only the next result waits for it. synchronous reset clears all sums.
`timescale 1ns / 1ps
`default_nettype none
`include "vector_distance_metrics_macros.svh"

module vector_distance_metrics #(
   parameter int ELEM_WIDTH = vdm_pkg::ELEM_WIDTH_DEFAULT,
   parameter int ACC_WIDTH  = vdm_pkg::ACC_WIDTH_DEFAULT,
   parameter int REQ_W      = ((2 * ELEM_WIDTH + 7) / 8) * 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [REQ_W-1:0]               req_tdata,   // elem_a, elem_b
   input  logic                           req_tlast,   // last_elem
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [vdm_pkg::OUT_WIDTH-1:0]  rsp_tdata,   // metric_value
   output logic [1:0]                     rsp_tuser,   // zero_norm, saturated
   input  logic                           csr_wr_en,
   input  logic [1:0]                     csr_wr_data  // metric_select
);
   import vdm_pkg::*;

   ctl_state_type state_ff, state_in;
   metric_type    metric_ff;
   logic          last_ff;
   logic          rsp_valid_ff;
   logic [OUT_WIDTH-1:0] rsp_data_ff;
   logic [1:0]    rsp_user_ff;

   logic accept, mac_done, out_free, load_out, fin_start;
   logic signed [ELEM_WIDTH-1:0] elem_a, elem_b;
   logic signed [ACC_WIDTH-1:0]  dot_sum, norm_a_sum, norm_b_sum, diff_sq_sum;
   logic         sat_flag;
   result_type   fin_res;

   assign elem_a    = req_tdata[ELEM_WIDTH-1:0];
   assign elem_b    = req_tdata[2*ELEM_WIDTH-1:ELEM_WIDTH];
   assign accept    = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign fin_start = mac_done && last_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_MAC;
         ST_MAC:  if (mac_done) state_in = last_ff ? ST_FIN : ST_IDLE;
         ST_FIN:  if (fin_res.done) state_in = ST_HOLD;
         ST_HOLD: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = state_ff == ST_IDLE;
      load_out   = (state_ff == ST_HOLD) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         metric_ff    <= MET_DOT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            metric_ff <= metric_type'(csr_wr_data);
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         last_ff <= req_tlast;
      end
      if (load_out) begin
         rsp_data_ff <= fin_res.value;
         rsp_user_ff <= {sat_flag, fin_res.zero_norm};
      end
   end

   vdm_mac #(
      .ELEM_WIDTH(ELEM_WIDTH),
      .ACC_WIDTH (ACC_WIDTH)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .start      (accept),
      .clear      (load_out),
      .elem_a     (elem_a),
      .elem_b     (elem_b),
      .done       (mac_done),
      .dot_sum    (dot_sum),
      .norm_a_sum (norm_a_sum),
      .norm_b_sum (norm_b_sum),
      .diff_sq_sum(diff_sq_sum),
      .sat_flag   (sat_flag)
   );

   vdm_finish #(
      .ELEM_WIDTH(ELEM_WIDTH),
      .ACC_WIDTH (ACC_WIDTH)
   ) u_finish (
      .clock        (clock),
      .reset        (reset),
      .start        (fin_start),
      .metric_select(metric_ff),
      .dot_sum      (dot_sum),
      .norm_a_sum   (norm_a_sum),
      .norm_b_sum   (norm_b_sum),
      .diff_sq_sum  (diff_sq_sum),
      .result       (fin_res)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `VDM_ASSERT_NEVER(a_mac_done_state, clock, reset, mac_done && (state_ff != ST_MAC), "mac done outside accumulate phase")
   `VDM_ASSERT_NEVER(a_fin_done_state, clock, reset, fin_res.done && (state_ff != ST_FIN), "finish done outside finish phase")
   `VDM_ASSERT(a_zero_norm_value, clock, reset, (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == '0), "zero norm with nonzero value")
   `VDM_ASSERT(a_load_clears, clock, reset, load_out |=> !sat_flag && (dot_sum == '0), "sums not cleared after result")

endmodule

`default_nettype wire
